/* hdl/rasr_pkg.sv */
// Shared types and constants for the rational add/subtract/reduce core.
package rasr_pkg;
  localparam int unsigned WW = 66;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_CMP = 2'd2,
    KIND_RSV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZDEN  = 2'd1,
    ST_OVF   = 2'd2,
    ST_RSV   = 2'd3
  } status_e;

  typedef struct packed {
    logic           zden;
    logic [1:0]     kind;
    logic [WW-1:0]  ln;
    logic [WW-1:0]  ld;
    logic [WW-1:0]  rn;
    logic [WW-1:0]  rd;
  } job_t;

  typedef struct packed {
    logic          [31:0] num;
    logic          [30:0] den;
    logic                 eq;
    logic          [1:0]  status;
  } res_t;
endpackage

/* hdl/rasr_front.sv */
// Front end: accepts transactions, sign-extends operands, flags zero denominators.
module rasr_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      lhs_num_i,
  input  logic [31:0]      lhs_den_i,
  input  logic [31:0]      rhs_num_i,
  input  logic [31:0]      rhs_den_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output rasr_pkg::job_t   job_o
);
  import rasr_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  job_t       buf_q [2];
  job_t       nj;
  logic       do_push, do_pop;

  function automatic logic [WW-1:0] sx(input logic [31:0] v);
    logic [DATA_WIDTH-1:0] t;
    t = v[DATA_WIDTH-1:0];
    return {{(WW-DATA_WIDTH){t[DATA_WIDTH-1]}}, t};
  endfunction

  always_comb begin
    nj.kind = kind_i;
    nj.ln   = sx(lhs_num_i);
    nj.ld   = sx(lhs_den_i);
    nj.rn   = sx(rhs_num_i);
    nj.rd   = sx(rhs_den_i);
    nj.zden = (lhs_den_i[DATA_WIDTH-1:0] == '0) || (rhs_den_i[DATA_WIDTH-1:0] == '0);
  end

  assign full_o      = cnt_q == 2'd2;
  assign do_push     = push_i && !full_o;
  assign job_valid_o = cnt_q != 2'd0;
  assign do_pop      = job_valid_o && job_ready_i;
  assign job_o       = buf_q[rp_q];
  assign cnt_d       = cnt_q + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= nj;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !job_valid_o == 1'b0) else $error("full but no job");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && !job_ready_i) |=> job_valid_o) else $error("job lost");
endmodule

/* hdl/rasr_divu.sv */
// Unsigned restoring divider, one quotient bit per cycle.
module rasr_divu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [rasr_pkg::WW-1:0] a_i,
  input  logic [rasr_pkg::WW-1:0] b_i,
  output logic                   done_o,
  output logic [rasr_pkg::WW-1:0] q_o
);
  import rasr_pkg::*;

  logic [WW-1:0] q_q, r_q, b_q;
  logic [6:0]    n_q;
  logic          busy_q;
  logic [WW:0]   sh;

  assign sh     = {r_q, q_q[WW-1]};
  assign q_o    = q_q;
  assign done_o = busy_q && (n_q == 7'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      n_q    <= 7'(WW);
    end else if (busy_q) begin
      if (n_q == 7'd0) busy_q <= 1'b0;
      else n_q <= n_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= a_i;
      r_q <= '0;
      b_q <= b_i;
    end else if (busy_q && n_q != 7'd0) begin
      if (sh >= {1'b0, b_q}) begin
        r_q <= WW'(sh - {1'b0, b_q});
        q_q <= {q_q[WW-2:0], 1'b1};
      end else begin
        r_q <= sh[WW-1:0];
        q_q <= {q_q[WW-2:0], 1'b0};
      end
    end
  end
endmodule

/* hdl/rasr_back.sv */
// Back end: reduces operands, then compares them or forms cross products, reduces and checks the result.
module rasr_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  rasr_pkg::job_t  job_i,
  output logic            empty_o,
  input  logic            pop_i,
  output rasr_pkg::res_t  res_o
);
  import rasr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SEL  = 10'b0000000010,
    S_GCD  = 10'b0000000100,
    S_DN   = 10'b0000001000,
    S_DD   = 10'b0000010000,
    S_FIX  = 10'b0000100000,
    S_MUL  = 10'b0001000000,
    S_ADD  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e        st_q;
  logic [1:0]    ph_q;
  logic [1:0]    kind_q;
  logic [WW-1:0] an_q, ad_q, bn_q, bd_q;
  logic [WW-1:0] n_q, d_q, qn_q;
  logic          sn_q, sd_q;
  logic [WW-1:0] ga_q, gb_q;
  logic [6:0]    gk_q;
  logic [WW-1:0] g_q;
  logic [WW-1:0] p0_q, p1_q, p2_q;
  res_t          res_q;
  res_t          hold_q;
  logic          full_q;
  logic          dv_done;
  logic [WW-1:0] dv_a, dv_q;
  logic [WW-1:0] rn, rd;
  logic [WW-1:0] lim;

  function automatic logic [WW-1:0] mg(input logic [WW-1:0] x);
    return x[WW-1] ? WW'(-x) : x;
  endfunction

  assign lim         = WW'(1) << (DATA_WIDTH - 1);
  assign job_ready_o = st_q == S_IDLE;
  assign empty_o     = !full_q;
  assign res_o       = hold_q;

  logic dv_go;
  assign dv_a = (st_q == S_DN) ? mg(n_q) : mg(d_q);

  rasr_divu u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_go),
    .a_i    (dv_a),
    .b_i    (g_q),
    .done_o (dv_done),
    .q_o    (dv_q)
  );

  logic started_q;
  assign dv_go = ((st_q == S_DN) || (st_q == S_DD)) && !started_q;

  always_comb begin
    rn = (qn_q == '0) ? '0 : ((sn_q ^ sd_q) ? WW'(-qn_q) : qn_q);
    rd = (qn_q == '0) ? WW'(1) : dv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      full_q    <= 1'b0;
      started_q <= 1'b0;
      ph_q      <= '0;
    end else begin
      if (st_q == S_OUT && (!full_q || pop_i)) full_q <= 1'b1;
      else if (pop_i && full_q) full_q <= 1'b0;
      case (st_q)
        S_IDLE: if (job_valid_i) begin
          kind_q <= job_i.kind;
          an_q <= job_i.ln; ad_q <= job_i.ld;
          bn_q <= job_i.rn; bd_q <= job_i.rd;
          if (job_i.zden) begin
            res_q <= '{num: '0, den: '0, eq: 1'b0, status: ST_ZDEN};
            st_q  <= S_OUT;
          end else begin
            ph_q <= 2'd0;
            st_q <= S_SEL;
          end
        end
        S_SEL: begin
          case (ph_q)
            2'd0: begin n_q <= an_q; d_q <= ad_q; end
            2'd1: begin n_q <= bn_q; d_q <= bd_q; end
            default: begin n_q <= p0_q; d_q <= p2_q; end
          endcase
          case (ph_q)
            2'd0: begin ga_q <= mg(an_q); gb_q <= mg(ad_q); end
            2'd1: begin ga_q <= mg(bn_q); gb_q <= mg(bd_q); end
            default: begin ga_q <= mg(p0_q); gb_q <= mg(p2_q); end
          endcase
          gk_q <= '0;
          st_q <= S_GCD;
        end
        S_GCD: begin
          if (ga_q == '0) begin
            g_q <= gb_q << gk_q; st_q <= S_DN;
          end else if (gb_q == '0) begin
            g_q <= ga_q << gk_q; st_q <= S_DN;
          end else if (!ga_q[0] && !gb_q[0]) begin
            ga_q <= ga_q >> 1; gb_q <= gb_q >> 1; gk_q <= gk_q + 7'd1;
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q >= gb_q) begin
            ga_q <= (ga_q - gb_q) >> 1;
          end else begin
            gb_q <= (gb_q - ga_q) >> 1;
          end
        end
        S_DN: begin
          started_q <= 1'b1;
          if (started_q && dv_done) begin
            qn_q <= dv_q; sn_q <= n_q[WW-1]; sd_q <= d_q[WW-1];
            started_q <= 1'b0; st_q <= S_DD;
          end
        end
        S_DD: begin
          started_q <= 1'b1;
          if (started_q && dv_done) begin
            started_q <= 1'b0; st_q <= S_FIX;
          end
        end
        S_FIX: begin
          case (ph_q)
            2'd0: begin an_q <= rn; ad_q <= rd; ph_q <= 2'd1; st_q <= S_SEL; end
            2'd1: begin
              bn_q <= rn; bd_q <= rd;
              if (kind_q == KIND_CMP || kind_q == KIND_RSV) begin
                res_q <= '{num: '0, den: '0,
                           eq: (an_q == rn) && (ad_q == rd), status: ST_OK};
                st_q <= S_OUT;
              end else begin
                st_q <= S_MUL;
              end
            end
            default: begin
              if ($signed(rn) < -$signed(lim) || $signed(rn) > $signed(lim - WW'(1)) ||
                  $signed(rd) > $signed(lim - WW'(1)))
                res_q <= '{num: '0, den: '0, eq: 1'b0, status: ST_OVF};
              else
                res_q <= '{num: 32'(rn), den: 31'(rd), eq: 1'b0, status: ST_OK};
              st_q <= S_OUT;
            end
          endcase
        end
        S_MUL: begin
          p0_q <= WW'($signed(an_q[33:0]) * $signed(bd_q[33:0]));
          p1_q <= WW'($signed(bn_q[33:0]) * $signed(ad_q[33:0]));
          st_q <= S_ADD;
        end
        S_ADD: begin
          p0_q <= (kind_q == KIND_SUB) ? p0_q - p1_q : p0_q + p1_q;
          p2_q <= WW'($signed(ad_q[33:0]) * $signed(bd_q[33:0]));
          st_q <= S_FIN;
        end
        S_FIN: begin
          ph_q <= 2'd2; st_q <= S_SEL;
        end
        S_OUT: if (!full_q || pop_i) begin
          hold_q <= res_q; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_oh: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("state not one-hot");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && !full_q) |=> full_q) else $error("result not stored");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> !started_q) else $error("divider busy while idle");
endmodule

/* hdl/rational_add_sub_reduce_core.sv */
// Top level of the rational add/subtract/compare core with gcd reduction.
// channel | dir | handshake     | fields
// input   | in  | push_i/full_o | kind, lhs_num, lhs_den, rhs_num, rhs_den
// result  | out | empty_o/pop_i | res_num, res_den, is_equal, status
// A zero denominator goes straight to the result; otherwise a reduction is a binary gcd loop
// plus two bit-serial divisions, and compare reduces twice, add and subtract three times.
// A two-entry queue decouples the front from the back; a finished result waits in the back
// until the output register is free, stalling the queue meanwhile.
// Reset is asynchronous, active low, and empties both queue and result register.
module rational_add_sub_reduce_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [31:0] lhs_num_i,
  input  logic [31:0] lhs_den_i,
  input  logic [31:0] rhs_num_i,
  input  logic [31:0] rhs_den_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        is_equal_o,
  output logic [1:0]  status_o
);
  import rasr_pkg::*;

  job_t job;
  logic jv, jr;
  res_t res;

  rasr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .kind_i, .lhs_num_i, .lhs_den_i, .rhs_num_i, .rhs_den_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  rasr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign res_num_o  = res.num;
  assign res_den_o  = res.den;
  assign is_equal_o = res.eq;
  assign status_o   = res.status;
endmodule

/* dv/tb_rational_add_sub_reduce_core.sv */
// Testbench for the rational add/subtract/compare core: directed and random transactions.
`timescale 1ns / 100ps

module tb_rational_add_sub_reduce_core;
  import rasr_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq;
    status_e     status;
  } frac_res_t;

  typedef struct {
    longint n;
    longint d;
  } frac_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int        errors;

    function longint unsigned magn(longint x);
      return x < 0 ? -x : x;
    endfunction

    function frac_t lowest_terms(longint n, longint d);
      frac_t f;
      longint unsigned a, b, t;
      a = magn(n);
      b = magn(d);
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      if (a == 0) a = 1;
      f.n = n / longint'(a);
      f.d = d / longint'(a);
      if (f.n == 0) f.d = 1;
      else if (f.d < 0) begin
        f.n = -f.n;
        f.d = -f.d;
      end
      return f;
    endfunction

    function void note_input(kind_e k, logic [31:0] ln, logic [31:0] ld,
                             logic [31:0] rn, logic [31:0] rd);
      frac_res_t r;
      frac_t a, b, s;
      longint cn;
      r.num = '0;
      r.den = '0;
      r.eq = 1'b0;
      r.status = ST_OK;
      if (ld == 0 || rd == 0) begin
        r.status = ST_ZDEN;
      end else begin
        a = lowest_terms(longint'(signed'(ln)), longint'(signed'(ld)));
        b = lowest_terms(longint'(signed'(rn)), longint'(signed'(rd)));
        if (k == KIND_CMP || k == KIND_RSV) begin
          r.eq = (a.n == b.n && a.d == b.d);
        end else begin
          cn = (k == KIND_ADD) ? a.n * b.d + b.n * a.d : a.n * b.d - b.n * a.d;
          s = lowest_terms(cn, a.d * b.d);
          if (s.n < -64'sd2147483648 || s.n > 64'sd2147483647 || s.d > 64'sd2147483647)
            r.status = ST_OVF;
          else begin
            r.num = s.n[31:0];
            r.den = s.d[30:0];
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] num, logic [30:0] den, logic eq,
                               logic [1:0] st);
      frac_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h", $time, num, den);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (num !== e.num) begin
        $display("%0t: res_num exp %h act %h", $time, e.num, num);
        errors++;
      end
      if (den !== e.den) begin
        $display("%0t: res_den exp %h act %h", $time, e.den, den);
        errors++;
      end
      if (eq !== e.eq) begin
        $display("%0t: is_equal exp %b act %b", $time, e.eq, eq);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status exp %0d act %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  kind_i = '0;
  logic [31:0] lhs_num_i = '0, lhs_den_i = '0, rhs_num_i = '0, rhs_den_i = '0;
  logic        full, empty, is_equal_o;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  status_o;

  frac_scoreboard fracs = new();
  bit  sending_done = 1'b0;
  int  hold_off = 0;

  rational_add_sub_reduce_core u_dut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .lhs_num_i, .lhs_den_i,
    .rhs_num_i, .rhs_den_i, .empty, .pop, .res_num_o, .res_den_o,
    .is_equal_o, .status_o
  );

  always #10 clk_i = ~clk_i;

  task automatic send_frac(kind_e k, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    lhs_num_i <= ln;
    lhs_den_i <= ld;
    rhs_num_i <= rn;
    rhs_den_i <= rd;
    do @(posedge clk_i); while (full);
    fracs.note_input(k, ln, ld, rn, rd);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7fff_ffff - $urandom_range(0, 3);
      4: return ($urandom_range(1, 60) * (1 << $urandom_range(0, 20)));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corners[6];
    kind_e k;
    corners = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0006};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_frac(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_frac(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_frac(KIND_CMP, 32'd2, 32'd4, -32'sd1, -32'sd2);
    send_frac(KIND_RSV, 32'd2, 32'd4, 32'd1, 32'd3);
    send_frac(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_frac(KIND_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
    send_frac(KIND_CMP, 32'd0, 32'd5, 32'd0, -32'sd7);
    send_frac(KIND_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_frac(KIND_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_frac(KIND_ADD, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1);
    send_frac(KIND_CMP, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_frac(KIND_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_frac(KIND_SUB, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 12; i++) begin
      k = kind_e'(i % 4);
      send_frac(k, corners[i % 6], corners[(i + 1) % 6], corners[(i + 3) % 6],
                corners[(i + 4) % 6]);
    end
    for (int i = 0; i < 1600; i++) begin
      logic [31:0] ln, ld;
      k = kind_e'($urandom_range(0, 3));
      ln = pick_value();
      ld = ($urandom_range(0, 30) == 0) ? 32'h0 : pick_value();
      if (ld == 0 && $urandom_range(0, 1)) ld = 32'd1;
      if (i == 400) hold_off = 4000;
      if (k == KIND_CMP && $urandom_range(0, 1)) begin
        send_frac(k, ln, ld, ln * 3, ld * 3);
      end else begin
        send_frac(k, ln, ld, pick_value(), ($urandom_range(0, 30) == 0) ? 32'h0
                  : (pick_value() | 32'h1));
      end
    end
    push <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        pop <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      fracs.check_result(res_num_o, res_den_o, is_equal_o, status_o);
    end
  end

  initial begin
    wait (sending_done);
    while (fracs.pending.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fracs.errors == 0 && fracs.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
hdl/rasr_pkg.sv
hdl/rasr_front.sv
hdl/rasr_divu.sv
hdl/rasr_back.sv
hdl/rational_add_sub_reduce_core.sv
dv/tb_rational_add_sub_reduce_core.sv
